### rtl/ldwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldwc_pkg
// Shared types and constants of the left decrease window check.
// ----------------------------------------------------------------------------
package ldwc_pkg;

	localparam int MAX_LEFT  = 16;
	localparam int FRAC_BITS = 16;

	// width of a step count 1..MAX_LEFT and of the saturating seen count
	localparam int IDX_W = $clog2(MAX_LEFT + 1);
	// width used when comparing counts against left_count
	localparam int LC_W  = 5;
	localparam int CMP_W = (IDX_W > LC_W) ? IDX_W : LC_W;
	// level * steps, signed
	localparam int PROD_W = 33 + IDX_W;

	localparam logic [63:0] MIN_LEVEL_RST_W = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
	localparam logic [63:0] MAX_LEVEL_RST_W = 64'd10 << FRAC_BITS;
	localparam logic [31:0] MIN_LEVEL_RST   = MIN_LEVEL_RST_W[31:0];
	localparam logic [31:0] MAX_LEVEL_RST   = MAX_LEVEL_RST_W[31:0];
	localparam logic [LC_W-1:0] LEFT_COUNT_RST = LC_W'(1);

	typedef enum logic [1:0] {
		REG_MIN_LEVEL  = 2'd0,
		REG_MAX_LEVEL  = 2'd1,
		REG_LEFT_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_NA   = 2'd0,
		VERDICT_FAIL = 2'd1,
		VERDICT_HOLD = 2'd2
	} verdict_t;

	typedef struct packed {
		logic signed [31:0] min_level;
		logic signed [31:0] max_level;
		logic [LC_W-1:0]    left_count;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/ldwc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldwc_cfg_regs
// Configuration register file: min_level, max_level, left_count.
// ----------------------------------------------------------------------------
module ldwc_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [31:0]   wr_data,
	output ldwc_pkg::cfg_t     cfg
);
	import ldwc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_level  <= MIN_LEVEL_RST;
			cfg_q.max_level  <= MAX_LEVEL_RST;
			cfg_q.left_count <= LEFT_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN_LEVEL:  cfg_q.min_level  <= wr_data;
				REG_MAX_LEVEL:  cfg_q.max_level  <= wr_data;
				REG_LEFT_COUNT: cfg_q.left_count <= wr_data[LC_W-1:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/ldwc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldwc_cell
// One history slot: holds a sample, shifts it on, checks its drop window
// and chains the fail flag to the next cell.
// ----------------------------------------------------------------------------
module ldwc_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      shift_en,
	input  wire logic [31:0]               prev_value,
	input  wire logic [31:0]               cur_sample,
	input  wire logic [31:0]               min_level,
	input  wire logic [31:0]               max_level,
	input  wire logic [ldwc_pkg::IDX_W-1:0] steps,
	input  wire logic                      active,
	input  wire logic                      fail_in,
	output logic [31:0]                    value,
	output logic                           fail_out
);
	import ldwc_pkg::*;

	logic [31:0]               value_q;
	logic signed [32:0]        diff;
	logic signed [PROD_W-1:0]  diff_ext;
	logic signed [PROD_W-1:0]  lo_ext;
	logic signed [PROD_W-1:0]  hi_ext;
	logic signed [IDX_W:0]     steps_ext;
	logic signed [PROD_W-1:0]  lo_bound;
	logic signed [PROD_W-1:0]  hi_bound;
	logic                      out_of_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift_en) begin
			value_q <= prev_value;
		end
	end

	// earlier sample minus current, exact in 33 bits
	assign diff      = {value_q[31], value_q} - {cur_sample[31], cur_sample};
	assign diff_ext  = {{IDX_W{diff[32]}}, diff};
	assign lo_ext    = {{(IDX_W + 1){min_level[31]}}, min_level};
	assign hi_ext    = {{(IDX_W + 1){max_level[31]}}, max_level};
	// level times a small step count, 32 x 5 bits
	assign steps_ext = {1'b0, steps};
	assign lo_bound  = lo_ext * steps_ext;
	assign hi_bound  = hi_ext * steps_ext;

	assign out_of_window = (diff_ext < lo_bound) || (diff_ext > hi_bound);

	assign value    = value_q;
	assign fail_out = fail_in | (active & out_of_window);

endmodule
`default_nettype wire

### rtl/left_decrease_window_check_core.sv
`default_nettype none
// A result beat is offered in the cycle after its sample beat is taken.
// Throughput: one sample per cycle while verdicts are taken; the whole window is
//   compared in the same cycle by the row of cells into one output register.
// Reset: clears the history to zero, the seen count to zero, the output
//   register to empty, and loads min_level, max_level, left_count defaults.
// ----------------------------------------------------------------------------
// left_decrease_window_check_core
// Checks that each of the last left_count samples minus the current one lies
// in [min_level*k, max_level*k], k the distance back. Q16.16 throughout.
// ----------------------------------------------------------------------------
module left_decrease_window_check_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
	input  wire logic        s_axis_tuser,   // [0] series_start
	// verdict output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [1:0] verdict, [7:2] zero
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import ldwc_pkg::*;

	cfg_t               cfg;
	logic               in_beat;
	logic [IDX_W-1:0]   seen_q;
	logic [IDX_W-1:0]   seen_eff;
	logic               too_few;
	logic [31:0]        cell_val [MAX_LEFT];
	logic [MAX_LEFT:0]  fail_chain;
	logic [MAX_LEFT-1:0] cell_active;
	verdict_t           verdict_d;
	verdict_t           verdict_q;
	logic               out_valid_q;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	ldwc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// output register frees up when its beat is taken, so a new sample can
	// enter in the same cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// series start wipes the count before the check
	assign seen_eff = s_axis_tuser ? '0 : seen_q;
	assign too_few  = CMP_W'(seen_eff) < CMP_W'(cfg.left_count);

	// row of cells; cell 0 holds the newest earlier sample
	assign fail_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_LEFT; i++) begin : g_cell
		localparam logic [IDX_W-1:0] STEP = IDX_W'(i + 1);

		// only the first left_count cells take part
		assign cell_active[i] = CMP_W'(STEP) <= CMP_W'(cfg.left_count);

		ldwc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (in_beat),
			.prev_value ((i == 0) ? s_axis_tdata : cell_val[(i == 0) ? 0 : i - 1]),
			.cur_sample (s_axis_tdata),
			.min_level  (cfg.min_level),
			.max_level  (cfg.max_level),
			.steps      (STEP),
			.active     (cell_active[i]),
			.fail_in    (fail_chain[i]),
			.value      (cell_val[i]),
			.fail_out   (fail_chain[i+1])
		);
	end

	// empty window (left_count zero) falls through as holds
	always_comb begin
		if (too_few) begin
			verdict_d = VERDICT_NA;
		end else if (fail_chain[MAX_LEFT]) begin
			verdict_d = VERDICT_FAIL;
		end else begin
			verdict_d = VERDICT_HOLD;
		end
	end

	// saturating count of earlier samples in this series
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_beat) begin
			if (seen_eff < IDX_W'(MAX_LEFT)) begin
				seen_q <= seen_eff + IDX_W'(1);
			end else begin
				seen_q <= seen_eff;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			verdict_q <= verdict_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, verdict_q};

`ifndef SYNTHESIS
	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= IDX_W'(MAX_LEFT))
		else $error("seen count above history depth");

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
		else $error("verdict code 3 offered");

	a_start_na: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_axis_tuser && (cfg.left_count != '0)) |=>
		(m_axis_tvalid && (m_axis_tdata[1:0] == VERDICT_NA)))
		else $error("series start not reported as not applicable");

	a_empty_window_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (cfg.left_count == '0)) |=>
		(m_axis_tvalid && (m_axis_tdata[1:0] == VERDICT_HOLD)))
		else $error("empty window did not hold");
`endif

endmodule
`default_nettype wire

### dv/tb_left_decrease_window_check_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_left_decrease_window_check_core
// Self-checking bench for the left decrease window check. A local window
// model predicts one verdict per sample beat and the monitor compares every
// verdict beat against it. Directed corner cases come first, then random
// phases of series with random levels and window sizes. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_left_decrease_window_check_core;
	import ldwc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1430;

	typedef struct packed {
		logic        opens;    // series_start
		logic [31:0] value;    // sample, Q16.16
	} sample_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] sample
	logic        s_axis_tuser = 1'b0; // [0] series_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [1:0] verdict, [7:2] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_MIN_LEVEL;
	logic [31:0] cfg_data = '0;

	left_decrease_window_check_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	// Mirror of the block's registers and window, updated on accepted beats.
	logic signed [31:0] min_lvl = MIN_LEVEL_RST;
	logic signed [31:0] max_lvl = MAX_LEVEL_RST;
	logic [4:0]         win_len = LEFT_COUNT_RST;
	logic signed [31:0] hist [MAX_LEFT];
	int                 seen = 0;

	initial begin
		for (int i = 0; i < MAX_LEFT; i++)
			hist[i] = '0;
	end

	// Verdict for sample x; shifts x into the window afterward.
	function automatic verdict_t window_verdict(logic signed [31:0] x, logic opens);
		verdict_t v;
		longint   lo;
		longint   hi;
		longint   d;
		int       i;
		lo = min_lvl;
		hi = max_lvl;
		if (opens)
			seen = 0;
		if (seen < int'(win_len)) begin
			v = VERDICT_NA;
		end else begin
			v = VERDICT_HOLD;
			// stop at the first distance that breaks the bound
			for (i = 0; i < int'(win_len) && i < MAX_LEFT && v == VERDICT_HOLD; i++) begin
				d = longint'(hist[i]) - longint'(x);
				if (d < lo * (i + 1) || d > hi * (i + 1))
					v = VERDICT_FAIL;
			end
		end
		for (i = MAX_LEFT - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = x;
		if (seen < MAX_LEFT)
			seen++;
		return v;
	endfunction

	// --------------------------------------------------------------- queues
	sample_beat_t sample_q [$];   // beats waiting for the driver
	verdict_t     verdict_q [$]; // verdicts owed by the block
	int           items_left = 0; // queued beats not yet taken
	int           cfg_count = 0;
	int           err_count = 0;
	int           idle_cycles = 0;
	bit           in_taken = 1'b0;
	bit           out_taken = 1'b0;
	int           in_pace = 0;
	int           out_pace = 0;
	int           in_gap = 0;
	int           out_stall = 0;

	task automatic report(string msg);
		$display("[%0t] %s", $time, msg);
		err_count++;
	endtask

	// pace 0: no idling, 1: occasional waits, 2: a random wait, possibly none, before every beat
	function automatic int draw_wait(int pace);
		if (pace == 0)
			return 0;
		if (pace == 1)
			return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
		return $urandom_range(0, 18);
	endfunction

	// ------------------------------------------------------ sampling side
	// Everything is sampled at the rising edge; flags hand over to the
	// falling-edge drivers.
	always @(posedge clk) begin
		in_taken = 1'b0;
		out_taken = 1'b0;
		if (arst_n) begin
			// a verdict leaving now belongs to an earlier sample, so check first
			if (m_axis_tvalid && m_axis_tready) begin
				out_taken = 1'b1;
				if (verdict_q.size() == 0) begin
					report($sformatf("verdict beat %0d with nothing expected",
						m_axis_tdata[1:0]));
				end else begin
					verdict_t want;
					want = verdict_q.pop_front();
					if (m_axis_tdata[1:0] != want)
						report($sformatf("verdict %0d, expected %s",
							m_axis_tdata[1:0], want.name()));
					if (m_axis_tdata[7:2] != '0)
						report($sformatf("tdata pad bits %b, expected zero",
							m_axis_tdata[7:2]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_taken = 1'b1;
				items_left--;
				verdict_q.push_back(window_verdict(s_axis_tdata, s_axis_tuser));
			end
			if (cfg_valid && cfg_ready) begin
				cfg_count++;
				case (cfg_index)
					REG_MIN_LEVEL:  min_lvl = cfg_data;
					REG_MAX_LEVEL:  max_lvl = cfg_data;
					REG_LEFT_COUNT: win_len = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_taken || out_taken || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------- driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (in_taken)
				in_gap = draw_wait(in_pace);
			if (in_gap != 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				sample_beat_t b;
				b = sample_q.pop_front();
				s_axis_tdata  <= b.value;
				s_axis_tuser  <= b.opens;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// verdict side back-pressure: a fresh stall draw after each beat
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				out_stall = draw_wait(out_pace);
			if (out_stall != 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------ stimulus
	task automatic queue_sample(logic [31:0] value, logic opens);
		sample_q.push_back('{opens: opens, value: value});
		items_left++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		int n;
		n = cfg_count;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		while (cfg_count == n)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender holds off until every owed verdict is back; registers are
	// only touched from here.
	task automatic drain();
		while (items_left != 0 || verdict_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		int          total;
		int          n_items;
		int          k;
		int          run;
		int          r;
		int          min_v;
		int          max_v;
		logic [31:0] cur;
		logic [31:0] s;
		logic        st;
		longint      lo;
		longint      hi;
		longint      drop;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// -- directed, reset levels (min 66, max 10.0, one sample back)
		queue_sample(32'h0010_0000, 1'b1);         // series start: not applicable
		queue_sample(32'h000F_0000, 1'b0);         // drop 1.0: holds
		queue_sample(32'h000F_0000, 1'b0);         // no drop: fails
		queue_sample(32'h000F_0000 - 66, 1'b0);    // drop exactly min: holds
		queue_sample(32'h000F_0000 - 131, 1'b0);   // drop min-1: fails
		queue_sample(32'h000E_FF7D - 655360, 1'b0); // drop exactly max: holds
		queue_sample(32'h000E_FF7D - 1310721, 1'b0); // drop max+1: fails
		queue_sample(32'h7FFF_FFFF, 1'b0);         // sample extremes
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h8000_0000, 1'b1);
		queue_sample(32'hFFFF_FFFF, 1'b0);
		drain();

		// empty window: holds on every sample, series start included
		write_reg(REG_LEFT_COUNT, 32'd0);
		queue_sample(32'h1234_5678, 1'b1);
		queue_sample(32'h7FFF_FFFF, 1'b0);
		drain();

		// window wider than storage: never applicable
		write_reg(REG_LEFT_COUNT, 32'd31);
		write_reg(REG_MIN_LEVEL, 32'h8000_0000);
		write_reg(REG_MAX_LEVEL, 32'h7FFF_FFFF);
		for (int i = 0; i < 3; i++)
			queue_sample($urandom, 1'b0);
		drain();

		// inverted levels: every applicable sample fails
		write_reg(REG_LEFT_COUNT, 32'd2);
		write_reg(REG_MIN_LEVEL, 32'd100);
		write_reg(REG_MAX_LEVEL, 32'd50);
		queue_sample(32'd1000, 1'b1);
		queue_sample(32'd925, 1'b0);
		queue_sample(32'd850, 1'b0);
		queue_sample(32'd775, 1'b0);
		drain();

		// -- random phases
		total = 0;
		while (total < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				write_reg(REG_LEFT_COUNT, 32'd0);
			else if (r == 1)
				write_reg(REG_LEFT_COUNT, $urandom_range(17, 31));
			else if (r == 2)
				write_reg(REG_LEFT_COUNT, MAX_LEFT);
			else
				write_reg(REG_LEFT_COUNT, $urandom_range(1, MAX_LEFT));

			r = $urandom_range(0, 9);
			if (r == 0) begin
				min_v = $urandom;
				max_v = $urandom;
			end else if (r == 1) begin
				min_v = 32'h8000_0000;
				max_v = 32'h7FFF_FFFF;
			end else if (r == 2) begin
				max_v = int'($urandom_range(0, 1 << 17)) - (1 << 15);
				min_v = max_v + int'($urandom_range(1, 1 << 16));
			end else begin
				min_v = int'($urandom_range(0, 1 << 17)) - (1 << 15);
				max_v = min_v + int'($urandom_range(0, 1 << 20));
			end
			write_reg(REG_MIN_LEVEL, min_v);
			write_reg(REG_MAX_LEVEL, max_v);
			lo = min_v;
			hi = max_v;
			in_pace = $urandom_range(0, 2);
			out_pace = $urandom_range(0, 2);

			// mostly series whose step drops sit inside the levels, with
			// out-of-range drops and raw noise mixed in
			n_items = $urandom_range(60, 180);
			if (n_items > RANDOM_ITEMS - total)
				n_items = RANDOM_ITEMS - total;
			k = 0;
			while (k < n_items) begin
				cur = $urandom;
				queue_sample(cur, 1'b1);
				k++;
				run = $urandom_range(1, 40);
				for (int j = 0; j < run && k < n_items; j++) begin
					r = $urandom_range(0, 19);
					if (r == 0) begin
						s = $urandom;
						st = 1'($urandom_range(0, 1));
					end else begin
						if (r == 1)
							drop = ($urandom_range(0, 1) != 0) ?
								lo - 1 - $urandom_range(0, 99) :
								hi + 1 + $urandom_range(0, 99);
						else if (hi >= lo)
							drop = lo + longint'($urandom) % (hi - lo + 1);
						else
							drop = longint'($urandom_range(0, 1 << 16));
						s = cur - drop[31:0];
						st = 1'b0;
					end
					queue_sample(s, st);
					cur = s;
					k++;
				end
			end
			total += n_items;
			drain();
		end

		repeat (5) @(posedge clk);
		if (err_count == 0 && verdict_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
